FILE: rtl/core/lzwd_pkg.sv
package lzwd_pkg;

    localparam int CODE_W_MAX    = 12;
    localparam int DEPTH         = 1 << CODE_W_MAX;
    localparam int ADDR_W        = CODE_W_MAX;
    localparam int CAP_W         = CODE_W_MAX + 1;
    localparam int CHUNK_BYTES   = 64;
    localparam int LANES         = CHUNK_BYTES / 8;
    localparam int CNT_W         = 7;
    localparam int MAX_RESULTS   = 64;
    localparam int MAX_TOTAL     = CHUNK_BYTES * MAX_RESULTS;
    localparam int DICT_W        = 1 + CODE_W_MAX + 8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CORRUPT = 2'd1;
    localparam logic [1:0] ST_LIMIT   = 2'd2;

    localparam logic [1:0] REG_CODE_BITS = 2'd0;
    localparam logic [1:0] REG_CLEAR     = 2'd1;
    localparam logic [1:0] REG_END       = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       sweep;
        logic       single;
        logic [1:0] single_stat;
        logic       clear_start;
        logic       walk_start;
        logic       walk_step;
        logic       walk_end;
        logic       commit;
        logic       emit_rd;
        logic       emit_wr;
        logic       present;
        logic       chunk_clear;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic clr;
        logic action_q;
        logic code_err;
        logic walk_more;
        logic walk_over;
        logic limit;
        logic more_bytes;
        logic chunk_full;
        logic out_busy;
        logic out_last;
    } t_sts;

endpackage

FILE: rtl/core/lzwd_if.sv
interface lzwd_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [11:0] code;
    logic [15:0] room;
    modport source (output valid, action, code, room, input ready);
    modport sink   (input valid, action, code, room, output ready);
endinterface

interface lzwd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] lane_0;
    logic [63:0] lane_1;
    logic [63:0] lane_2;
    logic [63:0] lane_3;
    logic [63:0] lane_4;
    logic [63:0] lane_5;
    logic [63:0] lane_6;
    logic [63:0] lane_7;
    logic [6:0]  byte_count;
    logic        last;
    logic [1:0]  status;
    modport source (output valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6,
                    lane_7, byte_count, last, status, input ready);
    modport sink   (input valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6,
                    lane_7, byte_count, last, status, output ready);
endinterface

interface lzwd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/lzwd_ram.sv
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/lzwd_ctrl.sv
module lzwd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lzwd_pkg::t_sts i_sts,
    output lzwd_pkg::t_cmd o_cmd
);
    localparam logic [3:0] S_SWEEP   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECIDE  = 4'd2;
    localparam logic [3:0] S_WALK    = 4'd3;
    localparam logic [3:0] S_CHECK   = 4'd4;
    localparam logic [3:0] S_EMIT_RD = 4'd5;
    localparam logic [3:0] S_EMIT_WR = 4'd6;
    localparam logic [3:0] S_OUT     = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    if (i_sts.clr) begin
                        o_cmd.single      = 1'b1;
                        o_cmd.single_stat = lzwd_pkg::ST_OK;
                        n_state           = S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.action_q) begin
                    o_cmd.clear_start = 1'b1;
                    n_state           = S_SWEEP;
                end else if (i_sts.code_err) begin
                    o_cmd.single      = 1'b1;
                    o_cmd.single_stat = lzwd_pkg::ST_CORRUPT;
                    n_state           = S_OUT;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.walk_over) begin
                    o_cmd.single      = 1'b1;
                    o_cmd.single_stat = lzwd_pkg::ST_CORRUPT;
                    n_state           = S_OUT;
                end else if (i_sts.walk_more) begin
                    o_cmd.walk_step = 1'b1;
                end else begin
                    o_cmd.walk_end = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.limit) begin
                    o_cmd.single      = 1'b1;
                    o_cmd.single_stat = lzwd_pkg::ST_LIMIT;
                    n_state           = S_OUT;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                if (i_sts.more_bytes && !i_sts.chunk_full) begin
                    o_cmd.emit_rd = 1'b1;
                    n_state       = S_EMIT_WR;
                end else begin
                    o_cmd.present = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_EMIT_WR: begin
                o_cmd.emit_wr = 1'b1;
                n_state       = S_EMIT_RD;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.chunk_clear = 1'b1;
                        n_state           = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/core/lzwd_dp.sv
module lzwd_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lzwd_pkg::t_cmd i_cmd,
    output lzwd_pkg::t_sts o_sts,
    lzwd_in_if.sink        i_in,
    lzwd_out_if.source     o_out,
    lzwd_cfg_if.sink       i_cfg
);
    localparam int AW = lzwd_pkg::ADDR_W;
    localparam int CW = lzwd_pkg::CAP_W;
    localparam int NB = lzwd_pkg::CHUNK_BYTES * 8;

    logic [3:0]    r_code_bits;
    logic [11:0]   r_clear_value;
    logic [11:0]   r_end_value;
    logic [CW-1:0] r_next;
    logic [AW-1:0] r_last_code;
    logic [7:0]    r_last_byte;
    logic          r_have_last;
    logic          r_action;
    logic [AW-1:0] r_code;
    logic [15:0]   r_room;
    logic          r_kwk;
    logic [AW-1:0] r_c;
    logic [CW-1:0] r_n;
    logic [7:0]    r_first;
    logic [AW-1:0] r_swp;
    logic          r_clr;
    logic [CW-1:0] r_rd;
    logic          r_xtra;
    logic          r_src_x;
    logic [NB-1:0] r_lanes;
    logic [lzwd_pkg::CNT_W-1:0] r_cnt;
    logic          r_oval;
    logic          r_olast;
    logic [1:0]    r_ostat;

    logic [3:0]    cb;
    logic [CW-1:0] cap;
    logic [CW-1:0] dict_base;
    logic [AW-1:0] lit;
    logic          kwk_now;
    logic [AW-1:0] walk_root;
    logic [CW-1:0] total;

    logic                        d_we;
    logic [AW-1:0]               d_waddr;
    logic [lzwd_pkg::DICT_W-1:0] d_wdata;
    logic [AW-1:0]               d_raddr;
    logic [lzwd_pkg::DICT_W-1:0] d_rdata;
    logic                        d_valid;
    logic [AW-1:0]               d_prefix;
    logic [7:0]                  d_byte;

    logic          s_we;
    logic [AW-1:0] s_waddr;
    logic [7:0]    s_wdata;
    logic [AW-1:0] s_raddr;
    logic [7:0]    s_rdata;
    logic [7:0]    emit_byte;
    logic          out_xfer;

    assign cb = (r_code_bits == 4'd0) ? 4'd1 :
                (r_code_bits > 4'(lzwd_pkg::CODE_W_MAX)) ?
                4'(lzwd_pkg::CODE_W_MAX) : r_code_bits;
    assign cap        = CW'(1) << cb;
    assign dict_base  = {1'b0, r_end_value} + CW'(1);
    assign lit        = ({1'b0, r_clear_value} < cap) ? r_clear_value : cap[AW-1:0];
    assign kwk_now    = ({1'b0, r_code} == r_next);
    assign walk_root  = kwk_now ? r_last_code : r_code;
    assign total      = r_n + CW'(r_kwk);

    assign d_valid  = d_rdata[lzwd_pkg::DICT_W-1];
    assign d_prefix = d_rdata[8 +: AW];
    assign d_byte   = d_rdata[7:0];

    assign d_raddr = i_cmd.walk_start ? walk_root : d_prefix;
    assign s_raddr = AW'(r_rd - CW'(1));
    assign out_xfer = r_oval && o_out.ready;
    assign emit_byte = r_src_x ? r_last_byte : s_rdata;

    always_comb begin
        d_we    = 1'b0;
        d_waddr = r_swp;
        d_wdata = '0;
        if (i_cmd.sweep) begin
            d_we = 1'b1;
        end else if (i_cmd.commit && r_have_last && (r_next < cap)) begin
            d_we    = 1'b1;
            d_waddr = r_next[AW-1:0];
            d_wdata = {1'b1, r_last_code, r_first};
        end
    end

    assign s_we    = i_cmd.walk_step || i_cmd.walk_end;
    assign s_waddr = r_n[AW-1:0];
    assign s_wdata = i_cmd.walk_step ? d_byte : r_c[7:0];

    lzwd_ram #(.WIDTH(lzwd_pkg::DICT_W), .DEPTH(lzwd_pkg::DEPTH)) u_dict (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    lzwd_ram #(.WIDTH(8), .DEPTH(lzwd_pkg::DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits   <= 4'd12;
            r_clear_value <= 12'd256;
            r_end_value   <= 12'd257;
            r_next        <= CW'(258);
            r_last_code   <= '0;
            r_last_byte   <= '0;
            r_have_last   <= 1'b0;
            r_swp         <= '0;
            r_clr         <= 1'b0;
            r_oval        <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    lzwd_pkg::REG_CODE_BITS: r_code_bits   <= i_cfg.data[3:0];
                    lzwd_pkg::REG_CLEAR:     r_clear_value <= i_cfg.data;
                    lzwd_pkg::REG_END:       r_end_value   <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_cmd.sweep) begin
                r_swp <= r_swp + AW'(1);
            end
            if (i_cmd.clear_start) begin
                r_swp       <= lit;
                r_clr       <= 1'b1;
                r_next      <= dict_base;
                r_last_code <= '0;
                r_last_byte <= '0;
                r_have_last <= 1'b0;
            end
            if (i_cmd.commit) begin
                if (r_have_last && (r_next < cap)) begin
                    r_next <= r_next + CW'(1);
                end
                r_last_code <= r_code;
                r_last_byte <= r_first;
                r_have_last <= 1'b1;
            end
            if (i_cmd.single) begin
                r_clr <= 1'b0;
            end
            if (i_cmd.single || i_cmd.present) begin
                r_oval <= 1'b1;
            end else if (out_xfer) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_in.action;
            r_code   <= i_in.code;
            r_room   <= i_in.room;
        end
        if (i_cmd.walk_start) begin
            r_kwk <= kwk_now;
            r_c   <= walk_root;
            r_n   <= '0;
        end
        if (i_cmd.walk_step) begin
            r_c <= d_prefix;
            r_n <= r_n + CW'(1);
        end
        if (i_cmd.walk_end) begin
            r_n     <= r_n + CW'(1);
            r_first <= r_kwk ? r_last_byte : r_c[7:0];
        end
        if (i_cmd.commit) begin
            r_rd <= r_n;
            r_xtra <= r_kwk;
        end
        if (i_cmd.commit || i_cmd.chunk_clear || i_cmd.single) begin
            r_lanes <= '0;
            r_cnt   <= '0;
        end
        if (i_cmd.emit_rd) begin
            if (r_rd != '0) begin
                r_rd    <= r_rd - CW'(1);
                r_src_x <= 1'b0;
            end else begin
                r_xtra  <= 1'b0;
                r_src_x <= 1'b1;
            end
        end
        if (i_cmd.emit_wr) begin
            r_lanes[{r_cnt[5:0], 3'b000} +: 8] <= emit_byte;
            r_cnt <= r_cnt + lzwd_pkg::CNT_W'(1);
        end
        if (i_cmd.single) begin
            r_olast <= 1'b1;
            r_ostat <= i_cmd.single_stat;
        end
        if (i_cmd.present) begin
            r_olast <= !((r_rd != '0) || r_xtra);
            r_ostat <= lzwd_pkg::ST_OK;
        end
    end

    assign o_sts.sweep_last = (r_swp == '1);
    assign o_sts.clr        = r_clr;
    assign o_sts.action_q   = r_action;
    assign o_sts.code_err   = ({1'b0, r_code} > r_next) || (kwk_now && !r_have_last);
    assign o_sts.walk_more  = (r_c >= dict_base[AW-1:0] || dict_base[CW-1]) ?
                              (!dict_base[CW-1] && ({1'b0, r_c} < cap) && d_valid) : 1'b0;
    assign o_sts.walk_over  = (r_n >= cap);
    assign o_sts.limit      = (16'(total) > r_room) || (total > CW'(lzwd_pkg::MAX_TOTAL));
    assign o_sts.more_bytes = (r_rd != '0) || r_xtra;
    assign o_sts.chunk_full = (r_cnt == lzwd_pkg::CNT_W'(lzwd_pkg::CHUNK_BYTES));
    assign o_sts.out_busy   = r_oval;
    assign o_sts.out_last   = r_olast;

    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_oval;
    assign o_out.lane_0     = r_lanes[0*64 +: 64];
    assign o_out.lane_1     = r_lanes[1*64 +: 64];
    assign o_out.lane_2     = r_lanes[2*64 +: 64];
    assign o_out.lane_3     = r_lanes[3*64 +: 64];
    assign o_out.lane_4     = r_lanes[4*64 +: 64];
    assign o_out.lane_5     = r_lanes[5*64 +: 64];
    assign o_out.lane_6     = r_lanes[6*64 +: 64];
    assign o_out.lane_7     = r_lanes[7*64 +: 64];
    assign o_out.byte_count = r_cnt;
    assign o_out.last       = r_olast;
    assign o_out.status     = r_ostat;
endmodule

FILE: rtl/core/lzw_code_decoder.sv
// Channel  Direction  Carries
// i_in     sink       action, code, room
// o_out    source     lane_0..lane_7, byte_count, last, status
// i_cfg    sink       index, data (code_bits, clear_value, end_value)
//
// A code is accepted, decided, walked with one dictionary read per entry and checked;
// its bytes are then unloaded from the stack one at a time into chunks, and each chunk
// is presented and transferred before the next one is built.
// Clear and reset run a pass over the dictionary, one entry a cycle from the
// literal count capped at capacity (reset: from entry 0) to entry 4095; no input
// is taken meanwhile. A stalled output holds the block until the chunk is transferred.
module lzw_code_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzwd_in_if.sink    i_in,
    lzwd_out_if.source o_out,
    lzwd_cfg_if.sink   i_cfg
);
    lzwd_pkg::t_cmd cmd;
    lzwd_pkg::t_sts sts;
    logic           in_ready;

    assign i_in.ready = in_ready;

    lzwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lzwd_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg)
    );

    a_idle_when_taking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready) |-> !o_out.valid)
        else $error("input taken while a result is pending");

    a_fault_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != lzwd_pkg::ST_OK) |->
        (o_out.byte_count == '0 && o_out.last))
        else $error("fault result carries bytes");

    a_sweep_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !in_ready)
        else $error("input taken during dictionary sweep");
endmodule

FILE: bench/tb_lzw_code_decoder.sv
module tb_lzw_code_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [511:0] data;
        logic [6:0]   byte_count;
        logic         last;
        logic [1:0]   status;
    } t_chunk;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lzwd_in_if  in_ch();
    lzwd_out_if out_ch();
    lzwd_cfg_if cfg_ch();

    lzw_code_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [3:0]  m_bits;
    logic [11:0] m_clear;
    logic [11:0] m_end;
    logic [11:0] m_prefix [lzwd_pkg::DEPTH];
    logic [7:0]  m_byte   [lzwd_pkg::DEPTH];
    logic        m_valid  [lzwd_pkg::DEPTH];
    int          m_next;
    logic [11:0] m_last_code;
    logic [7:0]  m_last_first;
    logic        m_have_last;
    logic [7:0]  m_stack  [lzwd_pkg::DEPTH + 1];
    logic [7:0]  m_out    [lzwd_pkg::DEPTH + 1];

    t_chunk chunks_due[$];
    int     errors = 0;
    int     cycles = 0;
    bit     no_idle = 0;
    bit     hold_req = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 30000000) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report(input string what, input logic [511:0] got, input logic [511:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    function automatic int cap_now();
        int b;
        b = m_bits;
        if (b < 1) b = 1;
        if (b > lzwd_pkg::CODE_W_MAX) b = lzwd_pkg::CODE_W_MAX;
        return 1 << b;
    endfunction

    function automatic void push_blank(input logic [1:0] st);
        t_chunk c;
        c.data = '0;
        c.byte_count = '0;
        c.last = 1'b1;
        c.status = st;
        chunks_due.push_back(c);
    endfunction

    // returns bytes pushed, 0 on an over-long chain
    function automatic int walk_chain(input int code, input int cap, output logic [7:0] first);
        int n;
        int c;
        n = 0;
        c = code;
        first = '0;
        while (c >= int'(m_end) + 1 && c < cap && m_valid[c]) begin
            if (n >= cap) return 0;
            m_stack[n] = m_byte[c];
            n++;
            c = m_prefix[c];
        end
        if (n >= cap) return 0;
        m_stack[n] = c[7:0];
        first = c[7:0];
        return n + 1;
    endfunction

    function automatic void predict_code(input logic action, input logic [11:0] code,
                                         input logic [15:0] room);
        int cap;
        int lit;
        int n;
        int total;
        int pos;
        int cnt;
        bit kwk;
        logic [7:0] first;
        t_chunk c;
        cap = cap_now();
        if (action) begin
            lit = (m_clear < cap) ? m_clear : cap;
            for (int i = lit; i < lzwd_pkg::DEPTH; i++) m_valid[i] = 1'b0;
            m_next = m_end + 1;
            m_last_code = '0;
            m_last_first = '0;
            m_have_last = 1'b0;
            push_blank(lzwd_pkg::ST_OK);
            return;
        end
        if (int'(code) > m_next) begin
            push_blank(lzwd_pkg::ST_CORRUPT);
            return;
        end
        kwk = (int'(code) == m_next);
        if (kwk) begin
            if (!m_have_last) begin
                push_blank(lzwd_pkg::ST_CORRUPT);
                return;
            end
            n = walk_chain(m_last_code, cap, first);
            first = m_last_first;
        end else begin
            n = walk_chain(code, cap, first);
        end
        if (n == 0) begin
            push_blank(lzwd_pkg::ST_CORRUPT);
            return;
        end
        total = kwk ? n + 1 : n;
        if (total > int'(room) || total > lzwd_pkg::MAX_TOTAL) begin
            push_blank(lzwd_pkg::ST_LIMIT);
            return;
        end
        pos = 0;
        for (int i = n; i > 0; i--) begin
            m_out[pos] = m_stack[i - 1];
            pos++;
        end
        if (kwk) m_out[pos] = m_last_first;
        if (m_have_last && m_next < cap) begin
            m_prefix[m_next] = m_last_code;
            m_byte[m_next] = first;
            m_valid[m_next] = 1'b1;
            m_next++;
        end
        m_last_code = code;
        m_last_first = first;
        m_have_last = 1'b1;
        for (pos = 0; pos < total; pos += lzwd_pkg::CHUNK_BYTES) begin
            cnt = total - pos;
            if (cnt > lzwd_pkg::CHUNK_BYTES) cnt = lzwd_pkg::CHUNK_BYTES;
            c.data = '0;
            for (int i = 0; i < cnt; i++) c.data[i*8 +: 8] = m_out[pos + i];
            c.byte_count = cnt[6:0];
            c.last = (pos + cnt >= total);
            c.status = lzwd_pkg::ST_OK;
            chunks_due.push_back(c);
        end
    endfunction

    task automatic send_code(input logic action, input logic [11:0] code,
                             input logic [15:0] room);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid  <= 1'b1;
        in_ch.action <= action;
        in_ch.code   <= code;
        in_ch.room   <= room;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_code(action, code, room);
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        idle_input();
        while (chunks_due.size() != 0) @(posedge i_clk);
        repeat (4300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [11:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (index)
            lzwd_pkg::REG_CODE_BITS: m_bits = data[3:0];
            lzwd_pkg::REG_CLEAR:     m_clear = data;
            lzwd_pkg::REG_END:       m_end = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input logic [11:0] bits, input logic [11:0] clr,
                             input logic [11:0] endv);
        drain();
        write_reg(lzwd_pkg::REG_CODE_BITS, bits);
        write_reg(lzwd_pkg::REG_CLEAR, clr);
        write_reg(lzwd_pkg::REG_END, endv);
        send_code(1'b1, 12'($urandom), 16'($urandom));
    endtask

    // receiver
    initial begin
        t_chunk c;
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                stall = 3000;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 14);
            end
            repeat (stall) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            if (chunks_due.size() == 0) begin
                report("unexpected transfer", '0, '0);
            end else begin
                c = chunks_due.pop_front();
                if ({out_ch.lane_7, out_ch.lane_6, out_ch.lane_5, out_ch.lane_4,
                     out_ch.lane_3, out_ch.lane_2, out_ch.lane_1, out_ch.lane_0} !== c.data)
                    report("lanes", {out_ch.lane_7, out_ch.lane_6, out_ch.lane_5,
                           out_ch.lane_4, out_ch.lane_3, out_ch.lane_2, out_ch.lane_1,
                           out_ch.lane_0}, c.data);
                if (out_ch.byte_count !== c.byte_count)
                    report("byte_count", 512'(out_ch.byte_count), 512'(c.byte_count));
                if (out_ch.last !== c.last)
                    report("last", 512'(out_ch.last), 512'(c.last));
                if (out_ch.status !== c.status)
                    report("status", 512'(out_ch.status), 512'(c.status));
            end
        end
    end

    function automatic logic [11:0] pick_code();
        int hi;
        int r;
        hi = (m_next > 4095) ? 4095 : m_next;
        r = $urandom_range(0, 99);
        if (r < 5) return 12'($urandom);
        if (r < 45 && hi > 20) return 12'($urandom_range(hi - 20, hi));
        return 12'($urandom_range(0, hi));
    endfunction

    function automatic logic [15:0] pick_room();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'($urandom_range(0, 40));
        if (r < 40) return 16'hFFFF;
        return 16'($urandom_range(4096, 65535));
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 3) send_code(1'b1, 12'($urandom), 16'($urandom));
            else send_code(1'b0, pick_code(), pick_room());
        end
    endtask

    task automatic test_directed();
        send_code(1'b0, 12'd258, 16'hFFFF);
        send_code(1'b0, 12'd65, 16'hFFFF);
        send_code(1'b0, 12'd0, 16'hFFFF);
        send_code(1'b0, 12'd255, 16'hFFFF);
        send_code(1'b0, 12'd258, 16'hFFFF);
        send_code(1'b0, 12'd261, 16'hFFFF);
        send_code(1'b0, 12'd262, 16'hFFFF);
        send_code(1'b0, 12'd4095, 16'hFFFF);
        send_code(1'b0, 12'd259, 16'd0);
        send_code(1'b0, 12'd260, 16'd2);
        send_code(1'b0, 12'd256, 16'hFFFF);
        send_code(1'b0, 12'd257, 16'd1);
        send_code(1'b1, 12'hFFF, 16'hFFFF);
        send_code(1'b0, 12'd258, 16'hFFFF);
        send_code(1'b0, 12'hAAA, 16'h5555);
        send_code(1'b0, 12'h555, 16'hAAAA);
    endtask

    task automatic test_small_dictionary();
        configure(12'd1, 12'd0, 12'd0);
        send_code(1'b0, 12'd0, 16'hFFFF);
        send_code(1'b0, 12'd1, 16'hFFFF);
        send_code(1'b0, 12'd1, 16'hFFFF);
        send_code(1'b0, 12'd2, 16'hFFFF);
        run_random(25);
        configure(12'd0, 12'd4095, 12'd4095);
        run_random(15);
        configure(12'd15, 12'd2, 12'd3);
        run_random(40);
    endtask

    task automatic test_long_strings();
        configure(12'd12, 12'd256, 12'd257);
        no_idle = 1;
        run_random(60);
        no_idle = 0;
        run_random(100);
    endtask

    task automatic test_back_pressure();
        configure(12'd9, 12'd16, 12'd17);
        hold_req = 1;
        run_random(80);
    endtask

    task automatic test_mixed_settings();
        configure(12'd4, 12'd8, 12'd9);
        run_random(50);
        configure(12'd10, 12'd4095, 12'd0);
        run_random(40);
        configure(12'd12, 12'd256, 12'd257);
        run_random(50);
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.action = 1'b0;
        in_ch.code   = '0;
        in_ch.room   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        m_bits = 4'd12;
        m_clear = 12'd256;
        m_end = 12'd257;
        for (int i = 0; i < lzwd_pkg::DEPTH; i++) begin
            m_valid[i] = 1'b0;
            m_prefix[i] = '0;
            m_byte[i] = '0;
        end
        m_next = 258;
        m_last_code = '0;
        m_last_first = '0;
        m_have_last = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_small_dictionary();
        test_long_strings();
        test_back_pressure();
        test_mixed_settings();
        idle_input();

        while (chunks_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/lzwd_pkg.sv
rtl/core/lzwd_if.sv
rtl/core/lzwd_ram.sv
rtl/core/lzwd_ctrl.sv
rtl/core/lzwd_dp.sv
rtl/core/lzw_code_decoder.sv
bench/tb_lzw_code_decoder.sv
